@@ design/spma_pkg.sv @@
// Shared constants, codes, microcode format and microprogram of the slot pool allocator.
`timescale 1ns / 1ps
package spma_pkg;

    // Pool geometry. The item fields are eight bits wide, which fixes the pool at 256 slots.
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = $clog2(WORD_BITS);
    localparam int WORD_COUNT = SLOT_COUNT / WORD_BITS;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    // Microprogram steps.
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UC_FETCH    = 3'd0;
    localparam logic [UPC_W-1:0] UC_ALLOC    = 3'd1;
    localparam logic [UPC_W-1:0] UC_ALLOC_WB = 3'd2;
    localparam logic [UPC_W-1:0] UC_MARK     = 3'd3;
    localparam logic [UPC_W-1:0] UC_SWEEP    = 3'd4;
    localparam logic [UPC_W-1:0] UC_EMIT     = 3'd5;

    // Jump conditions.
    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_GOTO     = 3'd1;
    localparam logic [2:0] JC_DISPATCH = 3'd2;
    localparam logic [2:0] JC_EMPTY    = 3'd3;
    localparam logic [2:0] JC_LOOP     = 3'd4;
    localparam logic [2:0] JC_HOLD     = 3'd5;

    typedef struct packed {
        logic             take;      // accept an item in this step
        logic             alloc_rd;  // pop: read the stack top
        logic             alloc_wb;  // pop: take the read data, set the used bit
        logic             mark;
        logic             sweep;     // examine one slot
        logic             emit;      // load the result register
        logic [2:0]       jc;
        logic [UPC_W-1:0] target;
    } t_uword;

    // Conditions that the datapath reports to the sequencer.
    typedef struct packed {
        logic       accept;
        logic [1:0] op;
        logic       pool_empty;
        logic       sweep_last;
        logic       out_free;
    } t_cond;

    function automatic t_uword uc_rom(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '0;
        case (upc)
            UC_FETCH: begin
                w.take = 1'b1;
                w.jc   = JC_DISPATCH;
            end
            UC_ALLOC: begin
                w.alloc_rd = 1'b1;
                w.jc       = JC_EMPTY;
                w.target   = UC_EMIT;
            end
            UC_ALLOC_WB: begin
                w.alloc_wb = 1'b1;
                w.jc       = JC_GOTO;
                w.target   = UC_EMIT;
            end
            UC_MARK: begin
                w.mark   = 1'b1;
                w.jc     = JC_GOTO;
                w.target = UC_EMIT;
            end
            UC_SWEEP: begin
                w.sweep  = 1'b1;
                w.jc     = JC_LOOP;
                w.target = UC_SWEEP;
            end
            UC_EMIT: begin
                w.emit   = 1'b1;
                w.jc     = JC_HOLD;
                w.target = UC_FETCH;
            end
            default: begin
                w.jc     = JC_GOTO;
                w.target = UC_FETCH;
            end
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] uc_dispatch(input logic [1:0] op);
        logic [UPC_W-1:0] s;
        case (op)
            OP_ALLOC: s = UC_ALLOC;
            OP_MARK:  s = UC_MARK;
            OP_SWEEP: s = UC_SWEEP;
            default:  s = UC_EMIT;
        endcase
        return s;
    endfunction

endpackage

@@ design/spma_in_if.sv @@
// Request channel: operation and slot index.
`timescale 1ns / 1ps
interface spma_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] slot;

    modport source (output valid, output op, output slot, input ready);
    modport sink   (input valid, input op, input slot, output ready);
endinterface

@@ design/spma_out_if.sv @@
// Result channel: handed out slot, status and pool counts.
`timescale 1ns / 1ps
interface spma_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] given_slot;
    logic [1:0] status;
    logic [8:0] free_slots;
    logic [8:0] freed_now;
    logic       pool_empty_of_use;

    modport source (output valid, output given_slot, output status, output free_slots,
                    output freed_now, output pool_empty_of_use, input ready);
    modport sink   (input valid, input given_slot, input status, input free_slots,
                    input freed_now, input pool_empty_of_use, output ready);
endinterface

@@ design/slot_pool_mark_sweep_allocator_top.sv @@
// Top level of the slot pool allocator: bitmaps, counters and result register.
//
//   channel   direction   handshake      payload
//   i_req     in          valid/ready    op, slot
//   o_rsp     out         valid/ready    given_slot, status, free_slots, freed_now,
//                                        pool_empty_of_use
//
// One item at a time runs through the microprogram. After fetch, allocate runs the
// read and write-back steps (read only on an empty pool), mark the mark step and
// sweep a sweep step per slot; all then end in the result step, as an unused code does.
// A sweep examines one slot per cycle; the write-back step takes the registered read data.
// Reset clears the sequencer, free count, output valid flag and bitmaps; no clearing pass.
// A result waits in the output register; the next item is accepted meanwhile, and
// its result step holds until the register is free.
`timescale 1ns / 1ps
module slot_pool_mark_sweep_allocator_top (
    input logic        i_clk,
    input logic        i_rst_n,
    spma_in_if.sink    i_req,
    spma_out_if.source o_rsp
);

    localparam int SW = spma_pkg::SLOT_W;
    localparam int CW = spma_pkg::CNT_W;
    localparam int WS = spma_pkg::WORD_SHIFT;

    spma_pkg::t_uword           uw;
    spma_pkg::t_cond            cond;
    logic [spma_pkg::UPC_W-1:0] upc;

    logic [spma_pkg::WORD_COUNT-1:0][spma_pkg::WORD_BITS-1:0] r_used, n_used;
    logic [spma_pkg::WORD_COUNT-1:0][spma_pkg::WORD_BITS-1:0] r_mark, n_mark;

    logic [CW-1:0] r_free, n_free;
    logic [CW-1:0] r_freed, n_freed;
    logic [SW-1:0] r_given, n_given;
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_op, n_op;
    logic [7:0]    r_slot, n_slot;
    logic [SW-1:0] r_idx, n_idx;

    logic          r_out_valid;
    logic [7:0]    r_o_given;
    logic [1:0]    r_o_status;
    logic [8:0]    r_o_free;
    logic [8:0]    r_o_freed;
    logic          r_o_all_free;

    logic          accept;
    logic          out_free;
    logic          emit_fire;
    logic          st_we, st_re;
    logic [SW-1:0] st_waddr, st_wdata, st_raddr, st_rdata;
    logic [CW-1:0] free_m1;
    logic          cur_used, cur_mark;
    logic          slot_used;

    assign accept    = i_req.valid && uw.take;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign emit_fire = uw.emit && out_free;
    assign free_m1   = r_free - CW'(1);

    assign cur_used  = r_used[r_idx[SW-1:WS]][r_idx[WS-1:0]];
    assign cur_mark  = r_mark[r_idx[SW-1:WS]][r_idx[WS-1:0]];
    assign slot_used = r_used[r_slot[SW-1:WS]][r_slot[WS-1:0]];

    assign cond.accept     = accept;
    assign cond.op         = i_req.op;
    assign cond.pool_empty = (r_free == '0);
    assign cond.sweep_last = (r_idx == SW'(spma_pkg::SLOT_COUNT - 1));
    assign cond.out_free   = out_free;

    spma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uword (uw),
        .o_upc   (upc)
    );

    spma_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    always_comb begin
        n_used   = r_used;
        n_mark   = r_mark;
        n_free   = r_free;
        n_freed  = r_freed;
        n_given  = r_given;
        n_status = r_status;
        n_op     = r_op;
        n_slot   = r_slot;
        n_idx    = r_idx;
        st_we    = 1'b0;
        st_re    = 1'b0;
        st_waddr = r_free[SW-1:0];
        st_wdata = r_idx;
        st_raddr = free_m1[SW-1:0];

        if (accept) begin
            n_op     = i_req.op;
            n_slot   = i_req.slot;
            n_given  = '0;
            n_status = spma_pkg::ST_OK;
            n_freed  = '0;
            n_idx    = '0;
        end

        if (uw.alloc_rd) begin
            if (r_free == '0) begin
                n_status = spma_pkg::ST_EMPTY;
            end else begin
                st_re  = 1'b1;
                n_free = free_m1;
            end
        end

        if (uw.alloc_wb) begin
            n_given = st_rdata;
            n_used[st_rdata[SW-1:WS]][st_rdata[WS-1:0]] = 1'b1;
        end

        if (uw.mark) begin
            if (!slot_used) begin
                n_status = spma_pkg::ST_NOT_USED;
            end else begin
                n_mark[r_slot[SW-1:WS]][r_slot[WS-1:0]] = 1'b1;
            end
        end

        if (uw.sweep) begin
            if (cur_used && cur_mark) begin
                n_mark[r_idx[SW-1:WS]][r_idx[WS-1:0]] = 1'b0;
            end else if (cur_used) begin
                // Unmarked slot in use goes back on the stack.
                n_used[r_idx[SW-1:WS]][r_idx[WS-1:0]] = 1'b0;
                if (r_free < CW'(spma_pkg::SLOT_COUNT)) begin
                    st_we  = 1'b1;
                    n_free = r_free + CW'(1);
                end
                n_freed = r_freed + CW'(1);
            end
            n_idx = r_idx + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_mark      <= '0;
            r_free      <= CW'(spma_pkg::SLOT_COUNT);
            r_out_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            r_mark <= n_mark;
            r_free <= n_free;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_freed  <= n_freed;
        r_given  <= n_given;
        r_status <= n_status;
        r_op     <= n_op;
        r_slot   <= n_slot;
        r_idx    <= n_idx;
        if (emit_fire) begin
            r_o_given    <= 8'(r_given);
            r_o_status   <= r_status;
            r_o_free     <= 9'(r_free);
            r_o_freed    <= 9'(r_freed);
            r_o_all_free <= (r_op == spma_pkg::OP_SWEEP) &&
                            (r_free == CW'(spma_pkg::SLOT_COUNT));
        end
    end

    assign i_req.ready             = uw.take;
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.given_slot        = r_o_given;
    assign o_rsp.status            = r_o_status;
    assign o_rsp.free_slots        = r_o_free;
    assign o_rsp.freed_now         = r_o_freed;
    assign o_rsp.pool_empty_of_use = r_o_all_free;

    // The free count never exceeds the pool size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(spma_pkg::SLOT_COUNT))
        else $error("free count above pool size");

    // An accepted item moves the sequencer out of the fetch step.
    a_leave_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (upc != spma_pkg::UC_FETCH))
        else $error("sequencer stayed in fetch after accepting an item");

    // A sweep step never lowers the free count.
    a_sweep_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upc == spma_pkg::UC_SWEEP) |=> (r_free >= $past(r_free)))
        else $error("free count dropped during sweep");

    // A result that reports a wholly free pool carries the full free count.
    a_all_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.pool_empty_of_use) |->
            (o_rsp.free_slots == 9'(spma_pkg::SLOT_COUNT)))
        else $error("pool reported free with slots in use");

endmodule

@@ design/spma_seq.sv @@
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps
module spma_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spma_pkg::t_cond               i_cond,
    output spma_pkg::t_uword              o_uword,
    output logic [spma_pkg::UPC_W-1:0]    o_upc
);

    logic [spma_pkg::UPC_W-1:0] r_upc;
    logic [spma_pkg::UPC_W-1:0] n_upc;
    spma_pkg::t_uword           uw;

    assign uw      = spma_pkg::uc_rom(r_upc);
    assign o_uword = uw;
    assign o_upc   = r_upc;

    always_comb begin
        case (uw.jc)
            spma_pkg::JC_NEXT:     n_upc = r_upc + spma_pkg::UPC_W'(1);
            spma_pkg::JC_GOTO:     n_upc = uw.target;
            spma_pkg::JC_DISPATCH: n_upc = i_cond.accept ? spma_pkg::uc_dispatch(i_cond.op)
                                                         : r_upc;
            spma_pkg::JC_EMPTY:    n_upc = i_cond.pool_empty ? uw.target
                                                             : r_upc + spma_pkg::UPC_W'(1);
            spma_pkg::JC_LOOP:     n_upc = i_cond.sweep_last ? r_upc + spma_pkg::UPC_W'(1)
                                                             : uw.target;
            spma_pkg::JC_HOLD:     n_upc = i_cond.out_free ? uw.target : r_upc;
            default:               n_upc = spma_pkg::UC_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= spma_pkg::UC_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

@@ design/spma_stack.sv @@
// Free slot stack memory; an entry never written reads as its reset index.
`timescale 1ns / 1ps
module spma_stack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [spma_pkg::SLOT_W-1:0]  i_waddr,
    input  logic [spma_pkg::SLOT_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [spma_pkg::SLOT_W-1:0]  i_raddr,
    output logic [spma_pkg::SLOT_W-1:0]  o_rdata
);

    logic [spma_pkg::SLOT_W-1:0]   r_mem [spma_pkg::SLOT_COUNT];
    logic [spma_pkg::SLOT_COUNT-1:0] r_vld;
    logic [spma_pkg::SLOT_W-1:0]   r_rd_data;
    logic [spma_pkg::SLOT_W-1:0]   r_rd_addr;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
            r_rd_addr <= i_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    // The reset content of entry k is SLOT_COUNT-1-k, which is the bitwise inverse of k.
    assign o_rdata = r_rd_vld ? r_rd_data : ~r_rd_addr;

endmodule

@@ verif/spma_pool_checker.sv @@
// Checker for the slot pool allocator: predicts every result and compares it field by field.
`timescale 1ns / 1ps
module spma_pool_checker
    import spma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    spma_in_if   req,
    spma_out_if  rsp,
    output int   o_fail_count,
    output int   o_awaited,
    output int   o_checked,
    output int   o_dry_allocs,
    output int   o_full_sweeps
);

    typedef struct packed {
        logic [SLOT_W-1:0] given_slot;
        logic [1:0]        status;
        logic [CNT_W-1:0]  free_slots;
        logic [CNT_W-1:0]  freed_now;
        logic              pool_empty_of_use;
    } t_pool_result;

    // Shadow copy of the pool.
    logic [SLOT_COUNT-1:0] in_use;
    logic [SLOT_COUNT-1:0] marked;
    logic [SLOT_W-1:0]     free_stack [SLOT_COUNT];
    logic [CNT_W-1:0]      free_depth;

    t_pool_result awaited_results[$];
    int fail_count   = 0;
    int checked      = 0;
    int dry_allocs   = 0;
    int full_sweeps  = 0;

    assign o_fail_count  = fail_count;
    assign o_checked     = checked;
    assign o_dry_allocs  = dry_allocs;
    assign o_full_sweeps = full_sweeps;

    initial o_awaited = 0;

    function automatic void pool_reset();
        in_use = '0;
        marked = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            free_stack[k] = SLOT_W'(SLOT_COUNT - 1 - k);
        end
        free_depth = CNT_W'(SLOT_COUNT);
    endfunction

    function automatic t_pool_result pool_apply(input logic [1:0] op, input logic [7:0] slot);
        t_pool_result r;
        r = '0;
        case (op)
            OP_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    free_depth = free_depth - 1'b1;
                    r.given_slot = free_stack[free_depth];
                    in_use[r.given_slot] = 1'b1;
                end
            end
            OP_MARK: begin
                if (!in_use[slot]) begin
                    r.status = ST_NOT_USED;
                end else begin
                    marked[slot] = 1'b1;
                end
            end
            OP_SWEEP: begin
                // Ascending walk, so the highest slot freed ends on top of the stack.
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (in_use[i]) begin
                        if (marked[i]) begin
                            marked[i] = 1'b0;
                        end else begin
                            in_use[i] = 1'b0;
                            if (free_depth < SLOT_COUNT) begin
                                free_stack[free_depth] = SLOT_W'(i);
                                free_depth = free_depth + 1'b1;
                            end
                            r.freed_now = r.freed_now + 1'b1;
                        end
                    end
                end
                r.pool_empty_of_use = (free_depth == SLOT_COUNT);
            end
            default: begin
            end
        endcase
        r.free_slots = free_depth;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("MISMATCH at %0t, result %0d: %s got %0d expected %0d",
                 $realtime, checked, what, got, want);
    endtask

    always @(posedge i_clk) begin : track
        t_pool_result want;
        if (!i_rst_n) begin
            pool_reset();
            awaited_results.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited, status", rsp.status, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (rsp.given_slot !== want.given_slot)
                        report_mismatch("given_slot", rsp.given_slot, want.given_slot);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.free_slots !== want.free_slots)
                        report_mismatch("free_slots", rsp.free_slots, want.free_slots);
                    if (rsp.freed_now !== want.freed_now)
                        report_mismatch("freed_now", rsp.freed_now, want.freed_now);
                    if (rsp.pool_empty_of_use !== want.pool_empty_of_use)
                        report_mismatch("pool_empty_of_use", rsp.pool_empty_of_use,
                                        want.pool_empty_of_use);
                    if (want.status == ST_EMPTY) dry_allocs++;
                    if (want.pool_empty_of_use) full_sweeps++;
                end
                checked++;
            end
            if (req.valid && req.ready) begin
                awaited_results.push_back(pool_apply(req.op, req.slot));
            end
        end
        o_awaited <= awaited_results.size();
    end

endmodule

@@ verif/tb_slot_pool_mark_sweep_allocator_top.sv @@
// Testbench top for the slot pool allocator: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_slot_pool_mark_sweep_allocator_top;
    import spma_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int EXHAUST_ALLOCS = 270;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spma_in_if  req_ch ();
    spma_out_if rsp_ch ();

    int fail_count;
    int awaited_count;
    int checked_count;
    int dry_allocs;
    int full_sweeps;

    int sent_by_op [4];
    int alloc_issued = 0;
    bit quiet = 1'b0;
    bit stall_sink_req = 1'b0;
    bit sink_held = 1'b0;

    always #1 i_clk = ~i_clk;

    slot_pool_mark_sweep_allocator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    spma_pool_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .o_fail_count  (fail_count),
        .o_awaited     (awaited_count),
        .o_checked     (checked_count),
        .o_dry_allocs  (dry_allocs),
        .o_full_sweeps (full_sweeps)
    );

    // Offers one item, possibly after an idle burst, and returns at the edge that takes it.
    task automatic send_item(input logic [1:0] op, input logic [7:0] slot);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.slot  <= slot;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_by_op[op]++;
        if (op == OP_ALLOC) alloc_issued++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_count != 0);
    endtask

    // Marks mostly aim at the low slots, which allocation hands out first.
    function automatic logic [7:0] pick_mark_slot();
        int hint;
        hint = (alloc_issued > 255) ? 255 : alloc_issued;
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, hint));
    endfunction

    // Result side flow control.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_sink_req && !sink_held) begin
                sink_held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int random_sent;
        int round;
        int n_alloc;
        int n_mark;
        int left;
        logic [1:0] op;
        random_sent = 0;
        round = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_ALLOC;
        req_ch.slot = 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: first allocations, marks on used, marked and free slots,
        // the unused code, a sweep that keeps a marked slot, one that frees all,
        // and a sweep of an already empty pool.
        quiet = 1'b1;
        send_item(OP_ALLOC, 8'hFF);
        send_item(OP_ALLOC, 8'h00);
        send_item(OP_MARK, 8'd0);
        send_item(OP_MARK, 8'd0);
        send_item(OP_MARK, 8'd255);
        send_item(OP_NONE, 8'hAA);
        send_item(OP_SWEEP, 8'h55);
        send_item(OP_SWEEP, 8'hFF);
        send_item(OP_SWEEP, 8'h00);
        send_item(OP_MARK, 8'd0);
        send_item(OP_ALLOC, 8'h55);
        send_item(OP_MARK, 8'h80);
        send_item(OP_NONE, 8'h55);
        send_item(OP_ALLOC, 8'hAA);
        send_item(OP_MARK, 8'd1);
        send_item(OP_SWEEP, 8'h0F);
        send_item(OP_SWEEP, 8'hF0);

        // Random rounds: a batch of allocations with marks mixed in, then a sweep.
        while (random_sent < RANDOM_ITEMS) begin
            quiet = (random_sent > RANDOM_ITEMS * 4 / 5) || ($urandom_range(0, 3) == 0);
            if (round == 1) stall_sink_req = 1'b1;
            if (round == 2) wait_drained();
            n_alloc = (round == 3) ? EXHAUST_ALLOCS : $urandom_range(1, 12);
            n_mark  = $urandom_range(0, 8);
            left = n_alloc + n_mark;
            while (left > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    op = 2'($urandom_range(0, 3));
                    send_item(op, 8'($urandom_range(0, 255)));
                    if (op != OP_NONE) random_sent++;
                end else if ($urandom_range(1, left) <= n_alloc) begin
                    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
                    n_alloc--;
                    left--;
                    random_sent++;
                end else begin
                    send_item(OP_MARK, pick_mark_slot());
                    n_mark--;
                    left--;
                    random_sent++;
                end
            end
            // Now and then a round ends without its sweep.
            if ($urandom_range(0, 7) != 0) begin
                send_item(OP_SWEEP, 8'($urandom_range(0, 255)));
                random_sent++;
            end
            round++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d allocates, %0d marks, %0d sweeps and %0d unused codes;",
                 sent_by_op[OP_ALLOC], sent_by_op[OP_MARK], sent_by_op[OP_SWEEP],
                 sent_by_op[OP_NONE]);
        $display("%0d results compared, %0d allocates on a dry pool, %0d sweeps left it free.",
                 checked_count, dry_allocs, full_sweeps);
        if (fail_count == 0 && awaited_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/spma_pkg.sv
design/spma_in_if.sv
design/spma_out_if.sv
design/spma_seq.sv
design/spma_stack.sv
design/slot_pool_mark_sweep_allocator_top.sv
verif/spma_pool_checker.sv
verif/tb_slot_pool_mark_sweep_allocator_top.sv
